/* rtl/latency_histogram_stats_macros.svh */
// Assertion helpers for the checker of the statistics unit.
// All of them sample on aclk and stay quiet while aresetn is low.
`ifndef LATENCY_HISTOGRAM_STATS_MACROS_SVH
`define LATENCY_HISTOGRAM_STATS_MACROS_SVH

// General property check
`define LHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Something must hold in the cycle after a stalled beat
`define LHS_ASSERT_STALL(lbl, vld, rdy, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (vld && !rdy) |=> (cons)) else $error(msg);

`endif

/* rtl/lhs_pkg.sv */
`default_nettype none

package lhs_pkg;

    // Histogram geometry
    localparam int HIST_BINS = 64;
    localparam int BIN_W     = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(HIST_BINS - 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int TIME_W  = 16;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 8;

    // Statistic reset values
    localparam logic [TIME_W-1:0] STAT_ALL_ONES  = 16'hFFFF;
    localparam logic [TIME_W-1:0] DEADLINE_RESET = 16'd18;
    localparam logic [TIME_W-1:0] HOLD_RESET     = 16'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FLOOR = 8'd1;

    // Opcodes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_START  = 2'd1,
        OP_REPORT = 2'd2
    } lhs_op_t;

    // Work kinds held in the queue
    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_START  = 2'd1,
        KIND_REPORT = 2'd2
    } lhs_kind_t;

    // Input beat payload, last field in the lowest bits
    typedef struct packed {
        logic              overcapture;
        logic [TIME_W-1:0] done_time;
        logic [TIME_W-1:0] edge_time;
    } lhs_in_t;

    localparam int IN_W      = $bits(lhs_in_t);
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;

    // Classified command passed from front to back
    typedef struct packed {
        lhs_kind_t         kind;
        logic [TIME_W-1:0] edge_time;
        logic [TIME_W-1:0] latency;
        logic [BIN_W-1:0]  bin;
        logic              miss;
        logic              hold;
        logic              overcapture;
    } lhs_entry_t;

    // Result beat payload, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] period_longest;
        logic [TIME_W-1:0] period_shortest;
        logic [TIME_W-1:0] latency_jitter;
        logic [SUM_W-1:0]  latency_sum;
        logic [TIME_W-1:0] latency_best;
        logic [TIME_W-1:0] latency_worst;
        logic [CNT_W-1:0]  overrun_count;
        logic [CNT_W-1:0]  hold_viol_cnt;
        logic [CNT_W-1:0]  deadline_miss_cnt;
        logic [CNT_W-1:0]  samples_run;
        logic [CNT_W-1:0]  bin_count;
    } lhs_result_t;

    localparam int RES_W     = $bits(lhs_result_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/lhs_front.sv */
`default_nettype none

module lhs_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lhs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [lhs_pkg::OP_W-1:0]        s_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lhs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lhs_pkg::TIME_W-1:0]      cfg_data,
    output logic                                 q_push,
    output lhs_pkg::lhs_entry_t                  q_entry,
    input  wire logic                            q_full
);
    import lhs_pkg::*;

    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] deadline_next;
    logic [TIME_W-1:0] hold_floor_reg;
    logic [TIME_W-1:0] hold_floor_next;

    lhs_in_t           in_beat;
    logic [TIME_W-1:0] lat;
    logic              keep;

    // Register writes, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        deadline_next   = deadline_reg;
        hold_floor_next = hold_floor_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_DEADLINE) begin
                deadline_next = cfg_data;
            end else if (cfg_index == CFG_HOLD_FLOOR) begin
                hold_floor_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg   <= DEADLINE_RESET;
            hold_floor_reg <= HOLD_RESET;
        end else begin
            deadline_reg   <= deadline_next;
            hold_floor_reg <= hold_floor_next;
        end
    end

    // Classify the beat: latency, bin and threshold flags
    assign in_beat  = s_tdata[IN_W-1:0];
    assign lat      = in_beat.done_time - in_beat.edge_time;
    assign s_tready = !q_full;

    always_comb begin
        keep                = 1'b1;
        q_entry.kind        = KIND_RECORD;
        q_entry.edge_time   = in_beat.edge_time;
        q_entry.latency     = lat;
        q_entry.bin         = (lat < TIME_W'(HIST_BINS)) ? lat[BIN_W-1:0] : BIN_LAST;
        q_entry.miss        = (lat > deadline_reg);
        q_entry.hold        = (lat < hold_floor_reg);
        q_entry.overcapture = in_beat.overcapture;
        case (s_tuser)
            OP_RECORD: q_entry.kind = KIND_RECORD;
            OP_START:  q_entry.kind = KIND_START;
            OP_REPORT: q_entry.kind = KIND_REPORT;
            default:   keep = 1'b0;
        endcase
    end

    // Unused opcode beats are taken and dropped
    assign q_push = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

/* rtl/lhs_queue.sv */
`default_nettype none

module lhs_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire lhs_pkg::lhs_entry_t  push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output lhs_pkg::lhs_entry_t       head,
    output logic                      empty
);
    import lhs_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    lhs_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/lhs_back.sv */
`default_nettype none

module lhs_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_empty,
    input  wire lhs_pkg::lhs_entry_t  q_head,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output lhs_pkg::lhs_result_t      m_result,
    output logic                      m_tlast
);
    import lhs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_REC_WR  = 4'b0010,
        S_REP_RD  = 4'b0100,
        S_REP_OUT = 4'b1000
    } lhs_state_t;

    lhs_state_t state_reg, state_next;

    // Running statistics
    logic [TIME_W-1:0]    prev_edge_reg, prev_edge_next;
    logic [CNT_W-1:0]     event_cnt_reg, event_cnt_next;
    logic [CNT_W-1:0]     miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]     hold_cnt_reg, hold_cnt_next;
    logic [CNT_W-1:0]     over_cnt_reg, over_cnt_next;
    logic [TIME_W-1:0]    worst_reg, worst_next;
    logic [TIME_W-1:0]    best_reg, best_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TIME_W-1:0]    pmin_reg, pmin_next;
    logic [TIME_W-1:0]    pmax_reg, pmax_next;

    // Histogram memory, one valid bit per bin stands in for a clear
    logic [CNT_W-1:0]     hist_mem [HIST_BINS];
    logic [HIST_BINS-1:0] hist_vld_reg, hist_vld_next;
    logic [CNT_W-1:0]     rd_data_reg;
    logic                 rd_vld_reg;
    logic [BIN_W-1:0]     rd_addr;
    logic                 hist_we;
    logic [CNT_W-1:0]     hist_wdata;
    logic [CNT_W-1:0]     rd_count;

    // Bin pointer: write address for a record, walk counter for a report
    logic [BIN_W-1:0]     bin_reg, bin_next;

    // Output register
    logic                 m_tvalid_reg, m_tvalid_next;
    lhs_result_t          m_result_reg;
    logic                 m_tlast_reg;
    logic                 out_free;
    logic                 out_load;
    logic [TIME_W-1:0]    per;

    assign rd_count   = rd_vld_reg ? rd_data_reg : '0;
    assign hist_wdata = rd_count + 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign per        = q_head.edge_time - prev_edge_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        prev_edge_next = prev_edge_reg;
        event_cnt_next = event_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        hold_cnt_next  = hold_cnt_reg;
        over_cnt_next  = over_cnt_reg;
        worst_next     = worst_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        pmin_next      = pmin_reg;
        pmax_next      = pmax_reg;
        hist_vld_next  = hist_vld_reg;
        bin_next       = bin_reg;
        rd_addr        = bin_reg;
        hist_we        = 1'b0;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                rd_addr = q_head.bin;
                if (!q_empty) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        KIND_RECORD: begin
                            prev_edge_next = q_head.edge_time;
                            event_cnt_next = event_cnt_reg + 1'b1;
                            if (q_head.overcapture) begin
                                over_cnt_next = over_cnt_reg + 1'b1;
                            end
                            if (q_head.miss) begin
                                miss_cnt_next = miss_cnt_reg + 1'b1;
                            end
                            if (q_head.hold) begin
                                hold_cnt_next = hold_cnt_reg + 1'b1;
                            end
                            if (q_head.latency > worst_reg) begin
                                worst_next = q_head.latency;
                            end
                            if (q_head.latency < best_reg) begin
                                best_next = q_head.latency;
                            end
                            sum_next = sum_reg + SUM_W'(q_head.latency);
                            if (per < pmin_reg) begin
                                pmin_next = per;
                            end
                            if (per > pmax_reg) begin
                                pmax_next = per;
                            end
                            bin_next   = q_head.bin;
                            state_next = S_REC_WR;
                        end
                        KIND_START: begin
                            prev_edge_next = q_head.edge_time;
                            event_cnt_next = '0;
                            miss_cnt_next  = '0;
                            hold_cnt_next  = '0;
                            over_cnt_next  = '0;
                            worst_next     = '0;
                            best_next      = STAT_ALL_ONES;
                            sum_next       = '0;
                            pmin_next      = STAT_ALL_ONES;
                            pmax_next      = '0;
                            hist_vld_next  = '0;
                        end
                        KIND_REPORT: begin
                            bin_next   = '0;
                            state_next = S_REP_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_REC_WR: begin
                // increment the bin read in the previous cycle
                hist_we                = 1'b1;
                hist_vld_next[bin_reg] = 1'b1;
                state_next             = S_IDLE;
            end
            S_REP_RD: begin
                state_next = S_REP_OUT;
            end
            S_REP_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (bin_reg == BIN_LAST) begin
                        state_next = S_IDLE;
                    end else begin
                        bin_next   = bin_reg + 1'b1;
                        state_next = S_REP_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_edge_reg <= '0;
            event_cnt_reg <= '0;
            miss_cnt_reg  <= '0;
            hold_cnt_reg  <= '0;
            over_cnt_reg  <= '0;
            worst_reg     <= '0;
            best_reg      <= STAT_ALL_ONES;
            sum_reg       <= '0;
            pmin_reg      <= STAT_ALL_ONES;
            pmax_reg      <= '0;
            hist_vld_reg  <= '0;
            bin_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_edge_reg <= prev_edge_next;
            event_cnt_reg <= event_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            hold_cnt_reg  <= hold_cnt_next;
            over_cnt_reg  <= over_cnt_next;
            worst_reg     <= worst_next;
            best_reg      <= best_next;
            sum_reg       <= sum_next;
            pmin_reg      <= pmin_next;
            pmax_reg      <= pmax_next;
            hist_vld_reg  <= hist_vld_next;
            bin_reg       <= bin_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Histogram memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[bin_reg] <= hist_wdata;
        end
        rd_data_reg <= hist_mem[rd_addr];
        rd_vld_reg  <= hist_vld_reg[rd_addr];
    end

    // Result beat payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_reg.bin_count         <= rd_count;
            m_result_reg.samples_run       <= event_cnt_reg;
            m_result_reg.deadline_miss_cnt <= miss_cnt_reg;
            m_result_reg.hold_viol_cnt     <= hold_cnt_reg;
            m_result_reg.overrun_count     <= over_cnt_reg;
            m_result_reg.latency_worst     <= worst_reg;
            m_result_reg.latency_best      <= best_reg;
            m_result_reg.latency_sum       <= sum_reg;
            m_result_reg.latency_jitter    <= worst_reg - best_reg;
            m_result_reg.period_shortest   <= pmin_reg;
            m_result_reg.period_longest    <= pmax_reg;
            m_tlast_reg                    <= (bin_reg == BIN_LAST);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_result = m_result_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* rtl/latency_histogram_stats.sv */
// Bus-timing statistics unit. Each input beat carries an opcode on s_tuser (record,
// start, report) and the edge time, done time and overcapture flag on s_tdata. The
// front end takes a beat in any cycle in which its two-entry command queue has room,
// works out latency, histogram bin and the deadline and hold-floor flags, and queues
// the command. The back end retires one command at a time: a record reads its bin and
// then writes it back (the histogram memory has one read and one write port), a start
// clears the statistics, and a report reads and sends each bin in turn, waiting while
// the result side stalls, with one beat per bin, tlast on the top bin. Every beat
// carries all the totals. A start clears the histogram through per-bin valid bits, so
// there is no clearing pass after reset or start. Registers 0 (deadline) and 1 (hold
// floor) are written over the cfg channel, which is always ready; write them only
// while the unit is idle.
`default_nettype none

module latency_histogram_stats (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: edge_time[15:0], done_time[31:16], overcapture[32], zero pad
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lhs_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  wire logic [lhs_pkg::OP_W-1:0]       s_tuser,
    // m_tdata: bin_count, samples_run, deadline_miss_cnt, hold_viol_cnt,
    // overrun_count (32 bit each), latency_worst, latency_best (16 bit each),
    // latency_sum (64 bit), latency_jitter, period_shortest, period_longest (16 bit each)
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lhs_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lhs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lhs_pkg::TIME_W-1:0]     cfg_data
);
    import lhs_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    lhs_entry_t  q_entry;
    lhs_entry_t  q_head;
    lhs_result_t m_result;

    lhs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_full    (q_full)
    );

    lhs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    lhs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(m_result);

endmodule

`default_nettype wire

/* rtl/lhs_checker.sv */
`default_nettype none
`include "latency_histogram_stats_macros.svh"

module lhs_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [lhs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           m_tlast
);
    import lhs_pkg::*;

    lhs_result_t        res;
    logic [M_TDATA_W:0] beat_bits;
    logic               jitter_ok;
    logic               latency_ok;
    logic               period_ok;

    assign res       = m_tdata[RES_W-1:0];
    assign beat_bits = {m_tlast, m_tdata};

    // Jitter agrees with the extremes it is derived from
    assign jitter_ok = (res.latency_jitter == TIME_W'(res.latency_worst - res.latency_best));

    // Extremes are either untouched or ordered
    assign latency_ok = (res.latency_best <= res.latency_worst) ||
                        ((res.latency_best == STAT_ALL_ONES) && (res.latency_worst == '0));
    assign period_ok  = (res.period_shortest <= res.period_longest) ||
                        ((res.period_shortest == STAT_ALL_ONES) && (res.period_longest == '0));

    // Result side holds a stalled beat
    `LHS_ASSERT_STALL(a_hold_valid, m_tvalid, m_tready, m_tvalid, "stalled beat dropped")
    `LHS_ASSERT_STALL(a_hold_data, m_tvalid, m_tready, $stable(beat_bits), "stalled beat changed")

    `LHS_ASSERT(a_jitter, m_tvalid |-> jitter_ok, "jitter does not match worst minus best")
    `LHS_ASSERT(a_latency_order, m_tvalid |-> latency_ok, "best latency above worst latency")
    `LHS_ASSERT(a_period_order, m_tvalid |-> period_ok, "shortest period above longest period")

endmodule

bind latency_histogram_stats lhs_checker u_lhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* test/latency_histogram_stats_tb.sv */
`timescale 1ns / 1ps

module latency_histogram_stats_tb;

    import lhs_pkg::*;

    // Opcode that the unit ignores, and register indexes that map to nothing
    localparam logic [OP_W-1:0]      OP_UNUSED       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_GAP        = 18;

    // One expected report beat
    typedef struct packed {
        lhs_result_t fields;
        logic        final_bin;
    } report_beat_t;

    // Statistics predictor and store of pending report beats
    class latency_stats_scoreboard;
        logic [CNT_W-1:0]  bin_hits [HIST_BINS];
        logic [TIME_W-1:0] prev_edge;
        logic [CNT_W-1:0]  events;
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  holds;
        logic [CNT_W-1:0]  overruns;
        logic [TIME_W-1:0] worst_seen;
        logic [TIME_W-1:0] best_seen;
        logic [SUM_W-1:0]  lat_total;
        logic [TIME_W-1:0] per_short;
        logic [TIME_W-1:0] per_long;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] hold_floor;
        report_beat_t      beats_due[$];
        int                errors = 0;

        function void clear_stats();
            foreach (bin_hits[i]) bin_hits[i] = '0;
            prev_edge  = '0;
            events     = '0;
            misses     = '0;
            holds      = '0;
            overruns   = '0;
            worst_seen = '0;
            best_seen  = STAT_ALL_ONES;
            lat_total  = '0;
            per_short  = STAT_ALL_ONES;
            per_long   = '0;
        endfunction

        function void power_on();
            clear_stats();
            deadline   = DEADLINE_RESET;
            hold_floor = HOLD_RESET;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
            if (idx == CFG_DEADLINE) begin
                deadline = value;
            end else if (idx == CFG_HOLD_FLOOR) begin
                hold_floor = value;
            end
        endfunction

        // Apply one accepted command; a report queues one beat per bin
        function void note_command(logic [OP_W-1:0] op, lhs_in_t beat);
            logic [TIME_W-1:0] lat;
            logic [TIME_W-1:0] per;
            logic [BIN_W-1:0]  bin;
            lhs_result_t       res;
            report_beat_t      due;
            case (op)
                OP_RECORD: begin
                    lat = beat.done_time - beat.edge_time;
                    per = beat.edge_time - prev_edge;
                    prev_edge = beat.edge_time;
                    if (beat.overcapture) overruns++;
                    if (lat > deadline) misses++;
                    if (lat < hold_floor) holds++;
                    if (lat > worst_seen) worst_seen = lat;
                    if (lat < best_seen) best_seen = lat;
                    lat_total += SUM_W'(lat);
                    if (per < per_short) per_short = per;
                    if (per > per_long) per_long = per;
                    bin = (lat < TIME_W'(HIST_BINS)) ? lat[BIN_W-1:0] : BIN_LAST;
                    bin_hits[bin]++;
                    events++;
                end
                OP_START: begin
                    clear_stats();
                    prev_edge = beat.edge_time;
                end
                OP_REPORT: begin
                    for (int k = 0; k < HIST_BINS; k++) begin
                        res.bin_count         = bin_hits[k];
                        res.samples_run       = events;
                        res.deadline_miss_cnt = misses;
                        res.hold_viol_cnt     = holds;
                        res.overrun_count     = overruns;
                        res.latency_worst     = worst_seen;
                        res.latency_best      = best_seen;
                        res.latency_sum       = lat_total;
                        res.latency_jitter    = worst_seen - best_seen;
                        res.period_shortest   = per_short;
                        res.period_longest    = per_long;
                        due.fields    = res;
                        due.final_bin = (k == HIST_BINS - 1);
                        beats_due.push_back(due);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [SUM_W-1:0] want,
                                    logic [SUM_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(lhs_result_t got, logic got_last);
            report_beat_t want;
            if (beats_due.size() == 0) begin
                $display("%0t: result beat with no report pending, bin_count %0h",
                         $time, got.bin_count);
                errors++;
                return;
            end
            want = beats_due.pop_front();
            compare_field("bin_count", SUM_W'(want.fields.bin_count),
                          SUM_W'(got.bin_count));
            compare_field("samples_run", SUM_W'(want.fields.samples_run),
                          SUM_W'(got.samples_run));
            compare_field("deadline_miss_cnt", SUM_W'(want.fields.deadline_miss_cnt),
                          SUM_W'(got.deadline_miss_cnt));
            compare_field("hold_viol_cnt", SUM_W'(want.fields.hold_viol_cnt),
                          SUM_W'(got.hold_viol_cnt));
            compare_field("overrun_count", SUM_W'(want.fields.overrun_count),
                          SUM_W'(got.overrun_count));
            compare_field("latency_worst", SUM_W'(want.fields.latency_worst),
                          SUM_W'(got.latency_worst));
            compare_field("latency_best", SUM_W'(want.fields.latency_best),
                          SUM_W'(got.latency_best));
            compare_field("latency_sum", want.fields.latency_sum, got.latency_sum);
            compare_field("latency_jitter", SUM_W'(want.fields.latency_jitter),
                          SUM_W'(got.latency_jitter));
            compare_field("period_shortest", SUM_W'(want.fields.period_shortest),
                          SUM_W'(got.period_shortest));
            compare_field("period_longest", SUM_W'(want.fields.period_longest),
                          SUM_W'(got.period_longest));
            compare_field("tlast", SUM_W'(want.final_bin), SUM_W'(got_last));
        endfunction

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    wire logic            s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    wire logic            m_tvalid;
    logic                 m_tready  = 1'b0;
    wire [M_TDATA_W-1:0]  m_tdata;
    wire logic            m_tlast;
    logic                 cfg_valid = 1'b0;
    wire logic            cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    latency_stats_scoreboard board = new;

    int commands_sent  = 0;
    int send_calm      = 0;
    int take_calm      = 0;
    int stalled_cycles = 0;

    latency_histogram_stats u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle cycles before the next beat; occasional calm stretches run flat out
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Latency mostly inside the histogram, some past the top bin, a few anywhere
    function automatic logic [TIME_W-1:0] pick_latency();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return TIME_W'($urandom_range(0, 70));
        if (roll < 9) return TIME_W'($urandom_range(60, 300));
        return TIME_W'($urandom);
    endfunction

    // Present one command beat; tvalid stays high when the next follows at once
    task automatic send_command(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] strobe_at,
                                input logic [TIME_W-1:0] done_at, input logic flagged);
        lhs_in_t beat;
        int      gap;
        beat.edge_time   = strobe_at;
        beat.done_time   = done_at;
        beat.overcapture = flagged;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(beat);
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(op, beat);
        if (op != OP_UNUSED) commands_sent++;
    endtask

    // Hold the sender until every report beat is in, then let the back end settle
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic drive_register(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.load_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Start, a run of events with plausible timing, then a report
    task automatic run_session();
        logic [TIME_W-1:0] strobe;
        int                n_events;
        strobe = TIME_W'($urandom);
        send_command(OP_START, strobe, TIME_W'($urandom), 1'($urandom));
        n_events = $urandom_range(1, 12);
        repeat (n_events) begin
            strobe += TIME_W'($urandom_range(0, 3000));
            send_command(OP_RECORD, strobe, strobe + pick_latency(), $urandom_range(0, 7) == 0);
        end
        send_command(OP_REPORT, TIME_W'($urandom), TIME_W'($urandom), 1'($urandom));
    endtask

    task automatic run_traffic(input int n_cmds);
        int target;
        target = commands_sent + n_cmds;
        while (commands_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
                run_session();
            end else begin
                send_command(OP_W'($urandom_range(0, 3)), TIME_W'($urandom),
                             TIME_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // Corner cases under the reset register values (deadline 18, hold floor 0)
    task automatic run_directed();
        // report straight after reset: no events, jitter wraps to 1
        send_command(OP_REPORT, 16'h0000, 16'h0000, 1'b0);
        send_command(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        // events before any start measure the period from edge zero
        send_command(OP_RECORD, 16'h0100, 16'h0112, 1'b0);
        send_command(OP_RECORD, 16'h0200, 16'h0213, 1'b1);
        send_command(OP_RECORD, 16'h0200, 16'h0200, 1'b0);
        send_command(OP_RECORD, 16'h0300, 16'h033F, 1'b0);
        send_command(OP_RECORD, 16'h0400, 16'h0440, 1'b0);
        // latency and period both wrapping
        send_command(OP_RECORD, 16'h0010, 16'h000F, 1'b1);
        send_command(OP_RECORD, 16'hFFFF, 16'h0002, 1'b0);
        send_command(OP_REPORT, 16'hFFFF, 16'hFFFF, 1'b1);
        send_command(OP_START, 16'hFFFF, 16'h0000, 1'b1);
        send_command(OP_RECORD, 16'h0000, 16'hFFFF, 1'b0);
        send_command(OP_RECORD, 16'hFFFF, 16'hFFFF, 1'b1);
        send_command(OP_REPORT, 16'h0000, 16'hFFFF, 1'b0);
        // start clears everything
        send_command(OP_START, 16'h0000, 16'hFFFF, 1'b0);
        send_command(OP_REPORT, 16'h1234, 16'h5678, 1'b0);
    endtask

    // Result side: random stalls per beat
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap(take_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_beat(lhs_result_t'(m_tdata[RES_W-1:0]), m_tlast);
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                         (cfg_valid && cfg_ready))) begin
            stalled_cycles++;
            if (stalled_cycles == WATCHDOG_LIMIT) begin
                $display("latency_histogram_stats regression: fail");
                $finish;
            end
        end else begin
            stalled_cycles = 0;
        end
    end

    // Main sequence
    initial begin
        board.power_on();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        // every latency short of 16'hFFFF below the floor, every nonzero latency a miss
        wait_for_idle();
        drive_register(CFG_DEADLINE, 16'h0000);
        drive_register(CFG_HOLD_FLOOR, 16'hFFFF);
        drive_register(CFG_UNMAPPED_LO, TIME_W'($urandom));
        run_traffic(50);

        // nothing misses, nothing violates the floor
        wait_for_idle();
        drive_register(CFG_DEADLINE, 16'hFFFF);
        drive_register(CFG_HOLD_FLOOR, 16'h0000);
        drive_register(CFG_UNMAPPED_HI, TIME_W'($urandom));
        run_traffic(50);

        // thresholds inside the typical latency spread
        wait_for_idle();
        drive_register(CFG_DEADLINE, TIME_W'($urandom_range(5, 60)));
        drive_register(CFG_HOLD_FLOOR, TIME_W'($urandom_range(0, 30)));
        run_traffic(50);

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("latency_histogram_stats regression: pass");
        end else begin
            $display("latency_histogram_stats regression: fail");
        end
        $finish;
    end

endmodule

/* latency_histogram_stats.f */
+incdir+rtl
rtl/lhs_pkg.sv
rtl/lhs_front.sv
rtl/lhs_queue.sv
rtl/lhs_back.sv
rtl/latency_histogram_stats.sv
rtl/lhs_checker.sv
test/latency_histogram_stats_tb.sv
